// File: sv/fsigm_pkg.sv
// Shared constants for the formula signature matcher: buffer size default,
// register indexes, the mark byte and the two signature tables.
// No dependencies; used by the top level by scoped names.
package fsigm_pkg;

  typedef logic [7:0] byte_t;

  localparam int BufferBytesDefault = 256;
  localparam int MinScanReset       = 19;

  // Configuration register indexes.
  localparam logic RegSignatureSet = 1'b0;
  localparam logic RegMinScanLength = 1'b1;

  localparam byte_t MarkByte = 8'h17;
  localparam int    SigMax   = 27;
  localparam int    SigCount = 3;

  // Signature lengths in bytes, not counting the leading mark byte.
  localparam logic [4:0] SigLen [2][SigCount] = '{
    '{5'd25, 5'd18, 5'd22},
    '{5'd27, 5'd19, 5'd23}
  };

  // Signature bytes that follow the mark byte; unused tail entries are zero.
  localparam byte_t SigTab [2][SigCount][SigMax] = '{
    '{
      '{8'h08, 8'h70, 8'h61, 8'h74, 8'h68, 8'h5F, 8'h78, 8'h6C, 8'h61, 8'h17,
        8'h0A, 8'h43, 8'h3A, 8'h5C, 8'h57, 8'h49, 8'h4E, 8'h44, 8'h4F, 8'h57,
        8'h53, 8'h42, 8'h02, 8'h58, 8'h00, 8'h00, 8'h00},
      '{8'h0C, 8'h5C, 8'h78, 8'h6C, 8'h73, 8'h68, 8'h65, 8'h65, 8'h74, 8'h2E,
        8'h78, 8'h6C, 8'h61, 8'h08, 8'h42, 8'h01, 8'hDE, 8'h81, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h11, 8'h45, 8'h6E, 8'h66, 8'h69, 8'h6E, 8'h20, 8'h6C, 8'h61, 8'h20,
        8'h70, 8'h61, 8'h69, 8'h78, 8'h20, 8'h2E, 8'h2E, 8'h2E, 8'h42, 8'h01,
        8'h06, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    },
    '{
      '{8'h08, 8'h00, 8'h70, 8'h61, 8'h74, 8'h68, 8'h5F, 8'h78, 8'h6C, 8'h61,
        8'h17, 8'h0A, 8'h00, 8'h43, 8'h3A, 8'h5C, 8'h57, 8'h49, 8'h4E, 8'h44,
        8'h4F, 8'h57, 8'h53, 8'h42, 8'h02, 8'h58, 8'h00},
      '{8'h0C, 8'h00, 8'h5C, 8'h78, 8'h6C, 8'h73, 8'h68, 8'h65, 8'h65, 8'h74,
        8'h2E, 8'h78, 8'h6C, 8'h61, 8'h08, 8'h42, 8'h01, 8'hDE, 8'h81, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h11, 8'h00, 8'h45, 8'h6E, 8'h66, 8'h69, 8'h6E, 8'h20, 8'h6C, 8'h61,
        8'h20, 8'h70, 8'h61, 8'h69, 8'h78, 8'h20, 8'h2E, 8'h2E, 8'h2E, 8'h42,
        8'h01, 8'h06, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}
    }
  };

endpackage

// File: sv/formula_signature_matcher_unit.sv
// Top level of the formula signature matcher: byte loader, scan sequencer
// and result register. Depends on fsigm_pkg and fsigm_ram.
//
// Usage: formula bytes arrive on the s_axis channel, one item per byte, with
// tlast on the final byte of a formula and tuser set on the first byte of a
// sheet (it clears the hit mask before that byte). Each formula yields one
// item on m_axis when its last byte has been processed: the hit mask and the
// found flag. The cfg channel writes signature_set (index 0) and
// min_scan_length (index 1); it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// A byte that is not the last one is taken while the loader is ready.
// After the last byte the scan sequencer walks the kept bytes through the
// buffer RAM's single read port: a read and a check per start position, a
// fit test per signature tried at a mark byte and a read and a compare per
// signature byte. The result is registered once the output register is
// free; the loader is not ready from the last byte until it is registered.
// Reset clears the byte count, the hit mask and the registers to their
// defaults (set 0, minimum length 19); the buffer needs no clearing. If the
// receiver stalls, the result waits in the output register, the next
// formula's bytes are still taken, and its scan result waits until the
// previous one has gone.
module formula_signature_matcher_unit #(
  parameter int BUFFER_BYTES = fsigm_pkg::BufferBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte input.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // formula_last
  input  logic       s_axis_tuser,   // [0] sheet_start
  // Result output.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] hit_mask, [3] virus_found, [7:4] zero
  // Configuration writes.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  localparam int AW       = $clog2(BUFFER_BYTES);
  localparam int CW       = $clog2(BUFFER_BYTES + 1);
  localparam int NW       = $clog2(BUFFER_BYTES + 512);
  localparam int CountCap = BUFFER_BYTES + 511;

  localparam logic [2:0] StLoad     = 3'd0;
  localparam logic [2:0] StMarkRd   = 3'd1;
  localparam logic [2:0] StMarkChk  = 3'd2;
  localparam logic [2:0] StSigStart = 3'd3;
  localparam logic [2:0] StSigRd    = 3'd4;
  localparam logic [2:0] StSigCmp   = 3'd5;
  localparam logic [2:0] StDone     = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [1:0]    sig_q, sig_d;
  logic [4:0]    idx_q, idx_d;
  logic [2:0]    hits_q, hits_d;
  logic          set_q;
  logic [8:0]    minlen_q;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_hits_q, out_hits_d;

  logic          in_acc;
  logic [NW-1:0] cnt_inc;
  logic [CW:0]   sig_end;
  logic [CW:0]   sig_addr;
  logic [4:0]    sig_len;
  logic [7:0]    sig_byte;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == StLoad);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, &out_hits_q, out_hits_q};

  assign cnt_inc  = (cnt_q < NW'(CountCap)) ? cnt_q + NW'(1) : cnt_q;
  assign ram_we   = in_acc && (cnt_q < NW'(BUFFER_BYTES));
  assign sig_len  = fsigm_pkg::SigLen[set_q][sig_q];
  assign sig_byte = fsigm_pkg::SigTab[set_q][sig_q][idx_q];
  // One adder serves both the fit test and the compare address.
  assign sig_end  = {1'b0, pos_q} + (CW+1)'(1)
                  + (CW+1)'((state_q == StSigStart) ? sig_len : idx_q);
  assign sig_addr = sig_end;
  assign ram_raddr = (state_q == StSigRd) ? sig_addr[AW-1:0] : pos_q[AW-1:0];

  fsigm_ram #(
    .Width (8),
    .Depth (BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kept_d      = kept_q;
    pos_d       = pos_q;
    sig_d       = sig_q;
    idx_d       = idx_q;
    hits_d      = hits_q;
    out_valid_d = out_valid_q;
    out_hits_d  = out_hits_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            hits_d = 3'b000;
          end
          cnt_d = cnt_inc;
          if (s_axis_tlast) begin
            cnt_d  = '0;
            pos_d  = '0;
            kept_d = (cnt_inc < NW'(BUFFER_BYTES)) ? cnt_inc[CW-1:0] : CW'(BUFFER_BYTES);
            state_d = (cnt_inc >= NW'(minlen_q)) ? StMarkRd : StDone;
          end
        end
      end
      StMarkRd: begin
        state_d = (pos_q == kept_q) ? StDone : StMarkChk;
      end
      StMarkChk: begin
        if (ram_rdata == fsigm_pkg::MarkByte) begin
          sig_d   = 2'd0;
          state_d = StSigStart;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = StMarkRd;
        end
      end
      StSigStart: begin
        if (!hits_q[sig_q] && (sig_end <= {1'b0, kept_q})) begin
          idx_d   = 5'd0;
          state_d = StSigRd;
        end else if (sig_q == 2'd2) begin
          pos_d   = pos_q + CW'(1);
          state_d = StMarkRd;
        end else begin
          sig_d = sig_q + 2'd1;
        end
      end
      StSigRd: begin
        state_d = StSigCmp;
      end
      StSigCmp: begin
        if (ram_rdata != sig_byte) begin
          if (sig_q == 2'd2) begin
            pos_d   = pos_q + CW'(1);
            state_d = StMarkRd;
          end else begin
            sig_d   = sig_q + 2'd1;
            state_d = StSigStart;
          end
        end else if (idx_q == sig_len - 5'd1) begin
          hits_d  = hits_q | (3'b001 << sig_q);
          state_d = StDone;
        end else begin
          idx_d   = idx_q + 5'd1;
          state_d = StSigRd;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_hits_d  = hits_q;
          state_d     = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      hits_q      <= 3'b000;
      set_q       <= 1'b0;
      minlen_q    <= 9'(fsigm_pkg::MinScanReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          fsigm_pkg::RegSignatureSet:  set_q    <= cfg_data_i[0];
          fsigm_pkg::RegMinScanLength: minlen_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kept_q     <= kept_d;
    pos_q      <= pos_d;
    sig_q      <= sig_d;
    idx_q      <= idx_d;
    out_hits_q <= out_hits_d;
  end

  // Every signature byte read lies inside the kept bytes.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSigRd) |-> (sig_addr < {1'b0, kept_q}))
    else $error("signature read past kept bytes");

  // Hit bits are only lost on a sheet start.
  a_hits_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s_axis_tuser) |=> ((hits_q & $past(hits_q)) == $past(hits_q)))
    else $error("hit bit lost without sheet start");

  // A scan sets at most one new hit bit per formula.
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |=> ($countones(hits_q & ~$past(hits_q)) <= 1))
    else $error("more than one hit bit set at once");

  // The loader is never ready while a scan is under way.
  a_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMarkRd || state_q == StSigRd) |-> !s_axis_tready)
    else $error("byte taken during scan");

endmodule

// File: sv/fsigm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fsigm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
